>>> hdl/priority_bypass_ring_queue_unit_defines.svh
// ----------------------------------------------------------------------------
// priority bypass ring queue assertion macros
// concurrent assertion wrappers used by the queue rtl
// ----------------------------------------------------------------------------
`ifndef PRIORITY_BYPASS_RING_QUEUE_UNIT_DEFINES_SVH
`define PRIORITY_BYPASS_RING_QUEUE_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define PBRQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PBRQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define PBRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/pbrq_pkg.sv
// ----------------------------------------------------------------------------
// pbrq_pkg
// shared types, codes and field layout of the priority bypass ring queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pbrq_pkg;

	localparam int QUEUE_DEPTH_DEF  = 128;
	localparam int KIND_BITS_DEF    = 4;
	localparam int PAYLOAD_BITS_DEF = 32;

	localparam int REQ_W     = 2;
	localparam int STATUS_W  = 2;
	localparam int KIND_W    = 4;
	localparam int PAYLOAD_W = 32;
	localparam int OCC_W     = 8;

	localparam int S_KIND_LO    = 0;
	localparam int S_PAYLOAD_LO = S_KIND_LO + KIND_W;
	localparam int S_TDATA_W    = ((KIND_W + PAYLOAD_W + 7) / 8) * 8;

	localparam int M_KIND_LO    = 0;
	localparam int M_PAYLOAD_LO = M_KIND_LO + KIND_W;
	localparam int M_OCC_LO     = M_PAYLOAD_LO + PAYLOAD_W;
	localparam int M_USED_W     = M_OCC_LO + OCC_W;
	localparam int M_TDATA_W    = ((M_USED_W + 7) / 8) * 8;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int CODE_W      = 4;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH = 2'd0,
		REQ_POP  = 2'd1,
		REQ_SHUT = 2'd2
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_REFUSED = 2'd1,
		ST_EMPTY   = 2'd2
	} status_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CAPACITY  = 2'd0,
		REG_CTL_CODE  = 2'd1,
		REG_MODE_CODE = 2'd2
	} reg_idx_t;

	// per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic load;
		logic shift;
		logic drop;
	} pbrq_ctl_t;

endpackage

`default_nettype wire

>>> hdl/pbrq_cell.sv
// ----------------------------------------------------------------------------
// pbrq_cell
// one queue slot; loads a pushed entry or takes the next or head entry on shift
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbrq_cell #(
	parameter int IDX          = 0,
	parameter int CW           = 8,
	parameter int KIND_BITS    = 4,
	parameter int PAYLOAD_BITS = 32
) (
	input  wire                        clk,
	input  pbrq_pkg::pbrq_ctl_t        ctl,
	input  wire  [CW-1:0]              cnt,
	input  wire  [KIND_BITS-1:0]       load_kind,
	input  wire  [PAYLOAD_BITS-1:0]    load_payload,
	input  wire  [KIND_BITS-1:0]       next_kind,
	input  wire  [PAYLOAD_BITS-1:0]    next_payload,
	input  wire  [KIND_BITS-1:0]       feed_kind,
	input  wire  [PAYLOAD_BITS-1:0]    feed_payload,
	output logic [KIND_BITS-1:0]       kind,
	output logic [PAYLOAD_BITS-1:0]    payload
);
	import pbrq_pkg::*;

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);
	localparam logic [CW-1:0] NXT    = CW'(IDX + 1);

	logic [KIND_BITS-1:0]    kind_q;
	logic [PAYLOAD_BITS-1:0] payload_q;
	logic                    take_next;
	logic                    take_feed;

	assign take_next = NXT < cnt;
	assign take_feed = (NXT == cnt) && !ctl.drop;

	always_ff @(posedge clk) begin
		if (ctl.load && (cnt == MY_IDX)) begin
			kind_q    <= load_kind;
			payload_q <= load_payload;
		end else if (ctl.shift) begin
			if (take_next) begin
				kind_q    <= next_kind;
				payload_q <= next_payload;
			end else if (take_feed) begin
				kind_q    <= feed_kind;
				payload_q <= feed_payload;
			end
		end
	end

	assign kind    = kind_q;
	assign payload = payload_q;

endmodule

`default_nettype wire

>>> hdl/priority_bypass_ring_queue_unit.sv
// ----------------------------------------------------------------------------
// priority_bypass_ring_queue_unit
// action queue with priority bypass on pop, built as a chain of slot cells
// ----------------------------------------------------------------------------
// Requests enter on the s_ beat channel, one result per request leaves on the
// m_ beat channel. cfg_ writes set capacity and the two priority kind codes;
// cfg_ready is always high and writes are expected only while the queue idles.
// Entries sit oldest first in a row of cells. A push loads the cell at the
// current occupancy. A pop rotates the held entries once around the occupied
// cells, one step per cycle, removing the first entry whose kind matches a
// priority code; without a match one more step removes the oldest.
// A new request is accepted only in the idle state, once the previous result
// has been taken into the output register.
// The result passes from the S_EMIT state into the m_tvalid output register.
// Reset empties the queue, clears shutdown, sets capacity to QUEUE_DEPTH and
// the priority codes to 0 and 1; no clearing pass is needed.
// A stalled receiver keeps the result in the output register; the next
// request is still accepted and worked, then waits until that beat leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "priority_bypass_ring_queue_unit_defines.svh"

module priority_bypass_ring_queue_unit #(
	parameter int QUEUE_DEPTH  = pbrq_pkg::QUEUE_DEPTH_DEF,
	parameter int KIND_BITS    = pbrq_pkg::KIND_BITS_DEF,
	parameter int PAYLOAD_BITS = pbrq_pkg::PAYLOAD_BITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// action_kind, action_payload, zero fill
	input  wire  [pbrq_pkg::S_TDATA_W-1:0]    s_tdata,
	// req_type
	input  wire  [pbrq_pkg::REQ_W-1:0]        s_tuser,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// popped_kind, popped_payload, occupancy, zero fill
	output logic [pbrq_pkg::M_TDATA_W-1:0]    m_tdata,
	// status
	output logic [pbrq_pkg::STATUS_W-1:0]     m_tuser,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [pbrq_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire  [pbrq_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import pbrq_pkg::*;

	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int CMPW = (KIND_BITS > CODE_W) ? KIND_BITS : CODE_W;
	localparam logic [CODE_W-1:0] CODE_MASK = CODE_W'((1 << KIND_BITS) - 1);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_HEAD,
		S_EMIT
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           cnt_q;
	logic [CW-1:0]           cap_q;
	logic [CW-1:0]           steps_q;
	logic                    shut_q;
	logic                    found_q;
	logic [CODE_W-1:0]       ctl_code_q;
	logic [CODE_W-1:0]       mode_code_q;
	status_t                 res_status_q;
	logic [KIND_BITS-1:0]    res_kind_q;
	logic [PAYLOAD_BITS-1:0] res_payload_q;
	logic                    m_tvalid_q;
	logic [M_TDATA_W-1:0]    m_tdata_q;
	logic [STATUS_W-1:0]     m_tuser_q;

	pbrq_ctl_t               ctl;
	logic                    s_accept;
	req_t                    req;
	logic                    refuse;
	logic                    hit;
	logic                    emit;
	logic [M_TDATA_W-1:0]    m_word;
	logic [KIND_BITS-1:0]    in_kind;
	logic [PAYLOAD_BITS-1:0] in_payload;

	logic [KIND_BITS-1:0]    kind_w    [QUEUE_DEPTH];
	logic [PAYLOAD_BITS-1:0] payload_w [QUEUE_DEPTH];

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign s_accept  = s_tvalid && s_tready;
	assign req       = req_t'(s_tuser);
	assign refuse    = shut_q || (cnt_q >= cap_q);
	assign in_kind    = KIND_BITS'(s_tdata[S_KIND_LO +: KIND_W]);
	assign in_payload = PAYLOAD_BITS'(s_tdata[S_PAYLOAD_LO +: PAYLOAD_W]);
	assign emit      = (state_q == S_EMIT) && (!m_tvalid_q || m_tready);

	assign hit = !found_q &&
		((CMPW'(kind_w[0]) == CMPW'(ctl_code_q)) ||
		 (CMPW'(kind_w[0]) == CMPW'(mode_code_q)));

	always_comb begin
		ctl.load  = s_accept && (req == REQ_PUSH) && !refuse;
		ctl.shift = (state_q == S_SCAN) || (state_q == S_HEAD);
		ctl.drop  = ((state_q == S_SCAN) && hit) || (state_q == S_HEAD);
	end

	always_comb begin
		m_word = '0;
		m_word[M_KIND_LO +: KIND_W]       = KIND_W'(res_kind_q);
		m_word[M_PAYLOAD_LO +: PAYLOAD_W] = PAYLOAD_W'(res_payload_q);
		m_word[M_OCC_LO +: OCC_W]         = OCC_W'(cnt_q);
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		if (i == QUEUE_DEPTH - 1) begin : g_last
			pbrq_cell #(
				.IDX          (i),
				.CW           (CW),
				.KIND_BITS    (KIND_BITS),
				.PAYLOAD_BITS (PAYLOAD_BITS)
			) u_cell (
				.clk          (clk),
				.ctl          (ctl),
				.cnt          (cnt_q),
				.load_kind    (in_kind),
				.load_payload (in_payload),
				.next_kind    (kind_w[0]),
				.next_payload (payload_w[0]),
				.feed_kind    (kind_w[0]),
				.feed_payload (payload_w[0]),
				.kind         (kind_w[i]),
				.payload      (payload_w[i])
			);
		end else begin : g_mid
			pbrq_cell #(
				.IDX          (i),
				.CW           (CW),
				.KIND_BITS    (KIND_BITS),
				.PAYLOAD_BITS (PAYLOAD_BITS)
			) u_cell (
				.clk          (clk),
				.ctl          (ctl),
				.cnt          (cnt_q),
				.load_kind    (in_kind),
				.load_payload (in_payload),
				.next_kind    (kind_w[i+1]),
				.next_payload (payload_w[i+1]),
				.feed_kind    (kind_w[0]),
				.feed_payload (payload_w[0]),
				.kind         (kind_w[i]),
				.payload      (payload_w[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			cap_q         <= DEPTH_CNT;
			steps_q       <= '0;
			shut_q        <= 1'b0;
			found_q       <= 1'b0;
			ctl_code_q    <= CODE_W'(0) & CODE_MASK;
			mode_code_q   <= CODE_W'(1) & CODE_MASK;
			res_status_q  <= ST_DONE;
			res_kind_q    <= '0;
			res_payload_q <= '0;
			m_tvalid_q    <= 1'b0;
			m_tdata_q     <= '0;
			m_tuser_q     <= '0;
		end else begin
			if (emit) begin
				m_tvalid_q <= 1'b1;
				m_tuser_q  <= res_status_q;
				m_tdata_q  <= m_word;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						res_kind_q    <= '0;
						res_payload_q <= '0;
						case (req)
							REQ_PUSH: begin
								res_status_q <= refuse ? ST_REFUSED : ST_DONE;
								state_q      <= S_EMIT;
								if (!refuse) begin
									cnt_q <= cnt_q + CW'(1);
								end
							end
							REQ_POP: begin
								if (cnt_q == '0) begin
									res_status_q <= ST_EMPTY;
									state_q      <= S_EMIT;
								end else begin
									res_status_q <= ST_DONE;
									steps_q      <= cnt_q;
									found_q      <= 1'b0;
									state_q      <= S_SCAN;
								end
							end
							REQ_SHUT: begin
								res_status_q <= ST_DONE;
								shut_q       <= 1'b1;
								state_q      <= S_EMIT;
							end
							default: begin
								res_status_q <= ST_DONE;
								state_q      <= S_EMIT;
							end
						endcase
					end
				end
				S_SCAN: begin
					steps_q <= steps_q - CW'(1);
					if (hit) begin
						found_q       <= 1'b1;
						res_kind_q    <= kind_w[0];
						res_payload_q <= payload_w[0];
						cnt_q         <= cnt_q - CW'(1);
					end
					if (steps_q == CW'(1)) begin
						state_q <= (found_q || hit) ? S_EMIT : S_HEAD;
					end
				end
				S_HEAD: begin
					res_kind_q    <= kind_w[0];
					res_payload_q <= payload_w[0];
					cnt_q         <= cnt_q - CW'(1);
					state_q       <= S_EMIT;
				end
				S_EMIT: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CAPACITY: begin
						if ((cfg_data == '0) || (32'(cfg_data) > 32'(QUEUE_DEPTH))) begin
							cap_q <= DEPTH_CNT;
						end else begin
							cap_q <= CW'(cfg_data);
						end
						cnt_q  <= '0;
						shut_q <= 1'b0;
					end
					REG_CTL_CODE: begin
						ctl_code_q <= cfg_data[CODE_W-1:0] & CODE_MASK;
					end
					REG_MODE_CODE: begin
						mode_code_q <= cfg_data[CODE_W-1:0] & CODE_MASK;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`PBRQ_ASSERT_ALWAYS(a_cnt_within_cap, clk, arst_n, cnt_q <= cap_q, "occupancy above capacity")
	`PBRQ_ASSERT_IMPL(a_scan_steps, clk, arst_n, state_q == S_SCAN, steps_q != '0, "scan with no steps left")
	`PBRQ_ASSERT_NEXT(a_head_drop, clk, arst_n, (state_q == S_HEAD) && !cfg_valid, cnt_q == ($past(cnt_q) - CW'(1)), "head pop did not remove an entry")
	`PBRQ_ASSERT_NEXT(a_found_kept, clk, arst_n, (state_q == S_SCAN) && found_q, found_q && (state_q != S_HEAD), "priority hit lost during scan")

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the priority bypass ring queue: requests are driven
// on the s_ beat channel with random gaps, each result beat is compared with
// an in-bench model of the queue that tracks capacity, shutdown and the two
// priority kind codes across several register settings
// ----------------------------------------------------------------------------

module tb_top;

	import pbrq_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam logic [REQ_W-1:0]       REQ_UNUSED = 2'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic [REQ_W-1:0]     req;
		logic [KIND_W-1:0]    kind;
		logic [PAYLOAD_W-1:0] payload;
	} request_t;

	typedef struct {
		logic [KIND_W-1:0]    kind;
		logic [PAYLOAD_W-1:0] payload;
	} action_t;

	typedef struct {
		status_t              status;
		logic [KIND_W-1:0]    kind;
		logic [PAYLOAD_W-1:0] payload;
		logic [OCC_W-1:0]     occ;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [REQ_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// model of the queue, oldest entry first
	action_t held_actions[$];
	bit      is_shut = 1'b0;
	int      capacity = QUEUE_DEPTH_DEF;
	logic [KIND_W-1:0] ctl_code = 4'd0;
	logic [KIND_W-1:0] mode_code = 4'd1;

	request_t request_backlog[$];
	answer_t  pending_answers[$];
	request_t on_bus;
	bit       s_taken = 1'b0;
	int       issued_count = 0;
	int       accepted_count = 0;
	int       error_count = 0;
	int       cycle_count = 0;
	int       send_idle_pct = 0;
	int       recv_idle_pct = 0;

	priority_bypass_ring_queue_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic answer_t apply_request(request_t rq);
		answer_t a;
		int pick;
		a.status = ST_DONE;
		a.kind = '0;
		a.payload = '0;
		case (rq.req)
			REQ_PUSH: begin
				if (is_shut || held_actions.size() >= capacity) begin
					a.status = ST_REFUSED;
				end else begin
					held_actions.push_back('{kind: rq.kind, payload: rq.payload});
				end
			end
			REQ_POP: begin
				if (held_actions.size() == 0) begin
					a.status = ST_EMPTY;
				end else begin
					pick = -1;
					foreach (held_actions[i]) begin
						if (pick < 0 && (held_actions[i].kind == ctl_code ||
								held_actions[i].kind == mode_code)) begin
							pick = i;
						end
					end
					if (pick < 0) begin
						pick = 0;
					end
					a.kind = held_actions[pick].kind;
					a.payload = held_actions[pick].payload;
					held_actions.delete(pick);
				end
			end
			REQ_SHUT: begin
				is_shut = 1'b1;
			end
			default: ;
		endcase
		a.occ = OCC_W'(held_actions.size());
		return a;
	endfunction

	function automatic void apply_register(logic [CFG_INDEX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_CAPACITY: begin
				capacity = (value == 0 || value > QUEUE_DEPTH_DEF) ? QUEUE_DEPTH_DEF : value;
				held_actions.delete();
				is_shut = 1'b0;
			end
			REG_CTL_CODE:  ctl_code = value[KIND_W-1:0];
			REG_MODE_CODE: mode_code = value[KIND_W-1:0];
			default: ;
		endcase
	endfunction

	// driver: request beats change on the falling edge
	always @(negedge clk) begin
		if (!s_tvalid || s_taken) begin
			s_taken = 1'b0;
			if (arst_n && request_backlog.size() > 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				on_bus = request_backlog.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= on_bus.req;
				s_tdata <= S_TDATA_W'({on_bus.payload, on_bus.kind});
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			s_taken = 1'b1;
			accepted_count++;
			pending_answers.push_back(apply_request(on_bus));
		end
	end

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			error_count++;
		end
	endtask

	// monitor: result beats sampled on the rising edge
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_answers.size() == 0) begin
				$error("result beat with no request outstanding");
				error_count++;
			end else begin
				want = pending_answers.pop_front();
				compare_field("status", 32'(want.status), 32'(m_tuser));
				compare_field("popped_kind", 32'(want.kind),
					32'(m_tdata[M_KIND_LO +: KIND_W]));
				compare_field("popped_payload", want.payload,
					m_tdata[M_PAYLOAD_LO +: PAYLOAD_W]);
				compare_field("occupancy", 32'(want.occ),
					32'(m_tdata[M_OCC_LO +: OCC_W]));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic enqueue_request(logic [REQ_W-1:0] req, logic [KIND_W-1:0] kind,
			logic [PAYLOAD_W-1:0] payload);
		request_backlog.push_back('{req: req, kind: kind, payload: payload});
		issued_count++;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (accepted_count != issued_count || pending_answers.size() != 0);
	endtask

	task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk);
		while (!cfg_ready);
		apply_register(idx, value);
	endtask

	task automatic set_registers(logic [CFG_DATA_W-1:0] cap, logic [CFG_DATA_W-1:0] ctl,
			logic [CFG_DATA_W-1:0] mode);
		wait_drained();
		repeat (4) @(negedge clk);
		write_register(REG_CAPACITY, cap);
		write_register(REG_CTL_CODE, ctl);
		write_register(REG_MODE_CODE, mode);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(logic [CFG_DATA_W-1:0] cap, logic [CFG_DATA_W-1:0] ctl,
			logic [CFG_DATA_W-1:0] mode, int push_pct, int count, int send_idle,
			int recv_idle);
		int r;
		logic [REQ_W-1:0] req;
		logic [KIND_W-1:0] kind;
		set_registers(cap, ctl, mode);
		send_idle_pct = send_idle;
		recv_idle_pct = recv_idle;
		for (int i = 0; i < count; i++) begin
			// sender holds off mid phase until every result is back
			if (i == count / 2) begin
				wait_drained();
			end
			r = $urandom_range(99);
			if (r < 2) begin
				req = REQ_UNUSED;
			end else if (i >= count - count / 10 && r < 5) begin
				req = REQ_SHUT;
			end else if (r < push_pct) begin
				req = REQ_PUSH;
			end else begin
				req = REQ_POP;
			end
			if ($urandom_range(3) == 0) begin
				kind = $urandom_range(1) ? ctl_code : mode_code;
			end else begin
				kind = KIND_W'($urandom_range(15));
			end
			enqueue_request(req, kind, $urandom);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset codes: control 0, mode switch 1
		enqueue_request(REQ_POP, 4'd0, 32'h0);
		enqueue_request(REQ_UNUSED, 4'd15, 32'hffffffff);
		enqueue_request(REQ_PUSH, 4'd15, 32'hffffffff);
		enqueue_request(REQ_PUSH, 4'd0, 32'h00000000);
		enqueue_request(REQ_PUSH, 4'd5, 32'ha5a5a5a5);
		enqueue_request(REQ_PUSH, 4'd1, 32'h5a5a5a5a);
		enqueue_request(REQ_POP, 4'd0, 32'h0);
		enqueue_request(REQ_POP, 4'd0, 32'h0);
		enqueue_request(REQ_POP, 4'd0, 32'h0);
		enqueue_request(REQ_PUSH, 4'd3, 32'h12345678);
		enqueue_request(REQ_SHUT, 4'd0, 32'h0);
		enqueue_request(REQ_PUSH, 4'd0, 32'hdeadbeef);
		enqueue_request(REQ_SHUT, 4'd0, 32'h0);
		enqueue_request(REQ_POP, 4'd0, 32'h0);
		enqueue_request(REQ_POP, 4'd0, 32'h0);
		enqueue_request(REQ_POP, 4'd0, 32'h0);

		// zero capacity maps to full depth, unknown index is dropped
		wait_drained();
		repeat (4) @(negedge clk);
		write_register(REG_CAPACITY, 8'd0);
		write_register(REG_UNUSED, 8'haa);
		@(negedge clk);
		cfg_valid <= 1'b0;
		set_registers(8'd2, 8'd15, 8'd15);
		enqueue_request(REQ_PUSH, 4'd7, 32'h80000000);
		enqueue_request(REQ_PUSH, 4'd15, 32'h00000001);
		enqueue_request(REQ_PUSH, 4'd9, 32'h7fffffff);
		enqueue_request(REQ_POP, 4'd0, 32'h0);
		enqueue_request(REQ_POP, 4'd0, 32'h0);
		enqueue_request(REQ_POP, 4'd0, 32'h0);

		run_phase(8'd1, 8'd0, 8'd15, 55, 160, 36, 79);
		run_phase(8'd4, 8'hf9, 8'd2, 55, 160, 36, 79);
		run_phase(8'd128, 8'd3, 8'd3, 80, 260, 36, 79);
		run_phase(8'd2, 8'd15, 8'd0, 55, 160, 79, 36);
		run_phase(8'd255, 8'd7, 8'd12, 80, 260, 79, 36);
		run_phase(8'd7, 8'd1, 8'd1, 55, 160, 79, 36);
		run_phase(8'd16, 8'd6, 8'd10, 60, 160, 0, 0);
		run_phase(8'd0, 8'd14, 8'd4, 80, 260, 0, 0);
		run_phase(8'd3, 8'd0, 8'd1, 55, 160, 0, 0);

		wait_drained();
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
